// ===== rtl/spa_pkg.sv =====
`default_nettype none

package spa_pkg;

    // fixed field widths of the request and result words
    localparam int REQ_BITS       = 2;
    localparam int IDX_BITS       = 8;
    localparam int VALUE_BITS     = 32;
    localparam int STATUS_BITS    = 2;
    localparam int SLOT_OUT_BITS  = 4;
    localparam int COUNT_OUT_BITS = 5;

    // parameter defaults
    localparam int DEF_SLOTS        = 16;
    localparam int DEF_ELEMENT_BITS = 32;

    // request codes
    localparam logic [REQ_BITS-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_ERASE  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_GET    = 2'd2;

    // status codes
    localparam logic [STATUS_BITS-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_FULL   = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_RANGE  = 2'd2;
    localparam logic [STATUS_BITS-1:0] STAT_UNUSED = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } spa_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_blocked;
    } spa_stat_t;

endpackage

`default_nettype wire

// ===== rtl/spa_req_if.sv =====
`default_nettype none

interface spa_req_if
    import spa_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [REQ_BITS-1:0]   req_type;
    logic [IDX_BITS-1:0]   slot_index;
    logic                  value_present;
    logic [VALUE_BITS-1:0] value;

    modport source (
        output valid, req_type, slot_index, value_present, value,
        input  ready
    );

    modport sink (
        input  valid, req_type, slot_index, value_present, value,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/spa_rsp_if.sv =====
`default_nettype none

interface spa_rsp_if
    import spa_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [STATUS_BITS-1:0]    status;
    logic [SLOT_OUT_BITS-1:0]  slot_out;
    logic [VALUE_BITS-1:0]     data_out;
    logic [COUNT_OUT_BITS-1:0] used_count;

    modport source (
        output valid, status, slot_out, data_out, used_count,
        input  ready
    );

    modport sink (
        input  valid, status, slot_out, data_out, used_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/spa_ram.sv =====
`default_nettype none

module spa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/spa_ctrl.sv =====
`default_nettype none

module spa_ctrl
    import spa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output      logic      in_ready,
    input  wire spa_stat_t stat,
    output      spa_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // request word is taken only between operations
    assign in_ready    = (state_reg == ST_IDLE);
    assign cmd.capture = in_valid && in_ready;
    assign cmd.lookup  = (state_reg == ST_LOOKUP);
    assign cmd.commit  = (state_reg == ST_COMMIT) && !stat.out_blocked;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!stat.out_blocked)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spa_datapath.sv =====
`default_nettype none

module spa_datapath
    import spa_pkg::*;
#(
    parameter int SLOTS        = DEF_SLOTS,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire spa_cmd_t              cmd,
    output      spa_stat_t             stat,
    input  wire logic [REQ_BITS-1:0]   req_type,
    input  wire logic [IDX_BITS-1:0]   slot_index,
    input  wire logic                  value_present,
    input  wire logic [VALUE_BITS-1:0] value,
    spa_rsp_if.source                  rsp
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IDX_BITS:0] IDX_LIMIT = (IDX_BITS + 1)'(SLOTS);
    localparam logic [CW-1:0]     CNT_FULL  = CW'(SLOTS);
    localparam logic [SW-1:0]     SLOT_LAST = SW'(SLOTS - 1);

    // latched request
    logic [REQ_BITS-1:0]     req_type_reg;
    logic [IDX_BITS-1:0]     idx_reg;
    logic                    present_reg;
    logic [ELEMENT_BITS-1:0] value_reg;

    // pool state
    logic [CW-1:0]    free_top_reg;
    logic [CW-1:0]    free_top_next;
    logic [CW-1:0]    used_total_reg;
    logic [CW-1:0]    used_total_next;
    logic [SLOTS-1:0] used_reg;
    logic [SLOTS-1:0] used_next;
    logic [SLOTS-1:0] stk_vld_reg;
    logic [SLOTS-1:0] stk_vld_next;
    logic [SLOTS-1:0] dat_vld_reg;
    logic [SLOTS-1:0] dat_vld_next;

    // result register
    logic                      rsp_valid_reg;
    logic [STATUS_BITS-1:0]    status_reg;
    logic [STATUS_BITS-1:0]    status_next;
    logic [SLOT_OUT_BITS-1:0]  slot_out_reg;
    logic [SLOT_OUT_BITS-1:0]  slot_out_next;
    logic [VALUE_BITS-1:0]     data_out_reg;
    logic [VALUE_BITS-1:0]     data_out_next;
    logic [COUNT_OUT_BITS-1:0] used_count_reg;

    // memory ports
    logic                    stk_wr_en;
    logic [SW-1:0]           stk_rd_data;
    logic                    dat_wr_en;
    logic [ELEMENT_BITS-1:0] dat_rd_data;

    logic [SW-1:0]           pop_addr;
    logic [SW-1:0]           push_addr;
    logic [SW-1:0]           idx_sw;
    logic [SW-1:0]           pop_slot;
    logic [ELEMENT_BITS-1:0] slot_word;
    logic                    in_range;

    assign pop_addr  = SW'(free_top_reg - CW'(1));
    assign push_addr = SW'(free_top_reg);
    assign idx_sw    = idx_reg[SW-1:0];
    assign in_range  = {1'b0, idx_reg} < IDX_LIMIT;

    // entries never written read as their reset contents
    assign pop_slot  = stk_vld_reg[pop_addr] ? stk_rd_data : (SLOT_LAST - pop_addr);
    assign slot_word = dat_vld_reg[idx_sw] ? dat_rd_data : '0;

    // free slot stack
    spa_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_stack (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (push_addr),
        .wr_data (idx_sw),
        .rd_en   (cmd.lookup),
        .rd_addr (pop_addr),
        .rd_data (stk_rd_data)
    );

    // slot data words
    spa_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (SLOTS)
    ) u_data (
        .clk     (clk),
        .wr_en   (dat_wr_en),
        .wr_addr (pop_slot),
        .wr_data (value_reg),
        .rd_en   (cmd.lookup),
        .rd_addr (idx_sw),
        .rd_data (dat_rd_data)
    );

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= req_type;
            idx_reg      <= slot_index;
            present_reg  <= value_present;
            value_reg    <= ELEMENT_BITS'(value);
        end
    end

    // request execution
    always_comb
    begin
        free_top_next   = free_top_reg;
        used_total_next = used_total_reg;
        used_next       = used_reg;
        stk_vld_next    = stk_vld_reg;
        dat_vld_next    = dat_vld_reg;
        stk_wr_en       = 1'b0;
        dat_wr_en       = 1'b0;
        status_next     = STAT_OK;
        slot_out_next   = SLOT_OUT_BITS'(idx_reg);
        data_out_next   = '0;
        case (req_type_reg)
            REQ_INSERT:
            begin
                if (free_top_reg == '0)
                begin
                    status_next   = STAT_FULL;
                    slot_out_next = '0;
                end
                else
                begin
                    free_top_next       = free_top_reg - CW'(1);
                    used_total_next     = used_total_reg + CW'(1);
                    used_next[pop_slot] = 1'b1;
                    slot_out_next       = SLOT_OUT_BITS'(pop_slot);
                    if (present_reg)
                    begin
                        dat_wr_en              = cmd.commit;
                        dat_vld_next[pop_slot] = 1'b1;
                    end
                end
            end
            REQ_ERASE, REQ_GET:
            begin
                if (!in_range)
                begin
                    status_next = STAT_RANGE;
                end
                else if (!used_reg[idx_sw])
                begin
                    status_next = STAT_UNUSED;
                end
                else
                begin
                    data_out_next = VALUE_BITS'(slot_word);
                    if (req_type_reg == REQ_ERASE)
                    begin
                        if (free_top_reg < CNT_FULL)
                        begin
                            stk_wr_en               = cmd.commit;
                            stk_vld_next[push_addr] = 1'b1;
                            free_top_next           = free_top_reg + CW'(1);
                        end
                        used_next[idx_sw] = 1'b0;
                        if (used_total_reg != '0)
                        begin
                            used_total_next = used_total_reg - CW'(1);
                        end
                    end
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    // pool state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_top_reg   <= CNT_FULL;
            used_total_reg <= '0;
            used_reg       <= '0;
            stk_vld_reg    <= '0;
            dat_vld_reg    <= '0;
        end
        else if (cmd.commit)
        begin
            free_top_reg   <= free_top_next;
            used_total_reg <= used_total_next;
            used_reg       <= used_next;
            stk_vld_reg    <= stk_vld_next;
            dat_vld_reg    <= dat_vld_next;
        end
    end

    // result word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg     <= status_next;
            slot_out_reg   <= slot_out_next;
            data_out_reg   <= data_out_next;
            used_count_reg <= COUNT_OUT_BITS'(used_total_next);
        end
    end

    assign stat.out_blocked = rsp_valid_reg && !rsp.ready;

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.slot_out   = slot_out_reg;
    assign rsp.data_out   = data_out_reg;
    assign rsp.used_count = used_count_reg;

endmodule

`default_nettype wire

// ===== rtl/slot_pool_allocator.sv =====
// slot_pool_allocator: fixed pool of SLOTS slots, each holding one data word
//
// req (sink): one request word per handshake: insert, erase or get.
// rsp (source): exactly one result word per request, in request order,
//   with status, slot, data and the count of used slots afterwards.
// each request passes through capture, a registered read of the
//   free-slot stack ram and the slot data ram, then the state update that
//   loads the result register. a new request is taken only once the
//   update of the previous one is done.
// the result register parts the two sides: a new request is taken while
//   the previous result still waits; if the receiver stalls, the next
//   update waits in its last step and req.ready stays low meanwhile.
// reset (rst_n, asynchronous, active low): all slots free, slot 0 handed
//   out first, all used bits and data words read as zero; per-entry valid
//   flops stand in for a clearing pass, so requests are taken at once.
`default_nettype none

module slot_pool_allocator
    import spa_pkg::*;
#(
    parameter int SLOTS        = DEF_SLOTS,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    spa_req_if.sink   req,
    spa_rsp_if.source rsp
);

    spa_cmd_t  cmd;
    spa_stat_t stat;

    // sequencer
    spa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // pool state, memories and result register
    spa_datapath #(
        .SLOTS        (SLOTS),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req.req_type),
        .slot_index    (req.slot_index),
        .value_present (req.value_present),
        .value         (req.value),
        .rsp           (rsp)
    );

    // the ram read lies between capture and update
    a_no_early_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !cmd.commit)
        else $error("update issued straight after capture");

    // no new request while one is being worked on
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |=> !req.ready)
        else $error("request taken during an update");

    // a fresh result only follows an update
    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(cmd.commit))
        else $error("result word without update");

    // a full report only when every slot is in use
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STAT_FULL) |-> rsp.used_count == COUNT_OUT_BITS'(SLOTS))
        else $error("pool full reported with free slots");

endmodule

`default_nettype wire
